// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RGB to HSV pixel unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication checked outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/rhsv_pkg.sv -----
// Types, constants and widths for the RGB to HSV pixel unit
`default_nettype none

package rhsv_pkg;

   // Field widths
   localparam int CH_W          = 8;
   localparam int HUE_W         = 15;
   localparam int SAT_W         = 16;

   // Hue fixed point and scaling
   localparam int HUE_FRAC_BITS = 6;
   localparam int HUE_SCALE     = 60 << HUE_FRAC_BITS;
   localparam int HUE_BASE_GRN  = 120 << HUE_FRAC_BITS;
   localparam int HUE_BASE_BLU  = 240 << HUE_FRAC_BITS;
   localparam int HUE_WRAP      = 360 << HUE_FRAC_BITS;
   localparam int HUE_SUM_W     = 20;

   localparam int SAT_FULL      = 65535;

   // One quotient bit per cell; both quotients fit in 16 bits
   localparam int DIV_STEPS     = 16;
   localparam int DVD_W         = CH_W + DIV_STEPS;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_in_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] saturation;
      logic [CH_W-1:0]  brightness;
   } pixel_out_type;

   // One restoring division in flight
   typedef struct packed {
      logic [CH_W-1:0]      rem;
      logic [DIV_STEPS-1:0] dvd;
      logic [DIV_STEPS-1:0] quo;
      logic [CH_W-1:0]      dsr;
   } div_lane_type;

   // Word handed from cell to cell
   typedef struct packed {
      div_lane_type    sat;
      div_lane_type    hue;
      logic [CH_W-1:0] brightness;
      sector_type      sector;
      logic            hue_neg;
      logic            sat_zero;
      logic            hue_zero;
   } cell_type;

endpackage

`default_nettype wire

// ----- hw/rtl/rhsv_front.sv -----
// Front stage: max, min, sector and dividend set-up, registered
`default_nettype none

module rhsv_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   output logic                   in_ready,
   input  rhsv_pkg::pixel_in_type in_pixel,
   output logic                   out_valid,
   input  wire                    out_ready,
   output rhsv_pkg::cell_type     out_cell
);

   logic                        valid_ff;
   rhsv_pkg::cell_type          cell_ff;
   rhsv_pkg::cell_type          cell_in;

   logic [rhsv_pkg::CH_W-1:0]   mx;
   logic [rhsv_pkg::CH_W-1:0]   mn;
   logic [rhsv_pkg::CH_W-1:0]   delta;
   logic signed [rhsv_pkg::CH_W:0] diff;
   logic [rhsv_pkg::CH_W-1:0]   mag;
   logic [rhsv_pkg::DVD_W-1:0]  sat_dvd;
   logic [rhsv_pkg::DVD_W-1:0]  hue_dvd;
   rhsv_pkg::sector_type        sector;

   // Channel extremes
   always_comb begin
      mx = in_pixel.red;
      if (in_pixel.green > mx) mx = in_pixel.green;
      if (in_pixel.blue > mx)  mx = in_pixel.blue;
      mn = in_pixel.red;
      if (in_pixel.green < mn) mn = in_pixel.green;
      if (in_pixel.blue < mn)  mn = in_pixel.blue;
      delta = mx - mn;
   end

   // Sector choice: red wins ties over green, green over blue
   always_comb begin
      priority if (in_pixel.red == mx) begin
         sector = rhsv_pkg::SECTOR_RED;
         diff   = $signed({1'b0, in_pixel.green}) - $signed({1'b0, in_pixel.blue});
      end else if (in_pixel.green == mx) begin
         sector = rhsv_pkg::SECTOR_GREEN;
         diff   = $signed({1'b0, in_pixel.blue}) - $signed({1'b0, in_pixel.red});
      end else begin
         sector = rhsv_pkg::SECTOR_BLUE;
         diff   = $signed({1'b0, in_pixel.red}) - $signed({1'b0, in_pixel.green});
      end
      mag = diff[rhsv_pkg::CH_W] ? rhsv_pkg::CH_W'(-diff) : diff[rhsv_pkg::CH_W-1:0];
   end

   // Dividends; top byte seeds the remainder, it is already below the divisor
   always_comb begin
      sat_dvd = rhsv_pkg::DVD_W'(32'(delta) * 32'(rhsv_pkg::SAT_FULL));
      hue_dvd = rhsv_pkg::DVD_W'(32'(mag) * 32'(rhsv_pkg::HUE_SCALE));

      cell_in.sat.rem   = sat_dvd[rhsv_pkg::DVD_W-1 -: rhsv_pkg::CH_W];
      cell_in.sat.dvd   = sat_dvd[rhsv_pkg::DIV_STEPS-1:0];
      cell_in.sat.quo   = '0;
      cell_in.sat.dsr   = mx;
      cell_in.hue.rem   = hue_dvd[rhsv_pkg::DVD_W-1 -: rhsv_pkg::CH_W];
      cell_in.hue.dvd   = hue_dvd[rhsv_pkg::DIV_STEPS-1:0];
      cell_in.hue.quo   = '0;
      cell_in.hue.dsr   = delta;
      cell_in.brightness = mx;
      cell_in.sector    = sector;
      cell_in.hue_neg   = diff[rhsv_pkg::CH_W];
      cell_in.sat_zero  = (mx == '0);
      cell_in.hue_zero  = (delta == '0);
   end

   assign in_ready = !valid_ff || out_ready;

   // Stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         cell_ff <= cell_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cell  = cell_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rhsv_div_cell.sv -----
// Division cell: one restoring quotient bit for both lanes, registered
`default_nettype none

module rhsv_div_cell (
   input  wire                clock,
   input  wire                reset,
   input  wire                in_valid,
   output logic               in_ready,
   input  rhsv_pkg::cell_type in_cell,
   output logic               out_valid,
   input  wire                out_ready,
   output rhsv_pkg::cell_type out_cell
);

   logic               valid_ff;
   rhsv_pkg::cell_type cell_ff;
   rhsv_pkg::cell_type cell_in;

   // Shift in the next dividend bit, subtract when it fits
   function automatic rhsv_pkg::div_lane_type div_step(input rhsv_pkg::div_lane_type lane);
      rhsv_pkg::div_lane_type  nxt;
      logic [rhsv_pkg::CH_W:0] trial;
      logic                    fits;
      trial = {lane.rem, lane.dvd[rhsv_pkg::DIV_STEPS-1]};
      fits  = (trial >= {1'b0, lane.dsr});
      nxt   = lane;
      nxt.rem = fits ? rhsv_pkg::CH_W'(trial - {1'b0, lane.dsr})
                     : trial[rhsv_pkg::CH_W-1:0];
      nxt.dvd = {lane.dvd[rhsv_pkg::DIV_STEPS-2:0], 1'b0};
      nxt.quo = {lane.quo[rhsv_pkg::DIV_STEPS-2:0], fits};
      return nxt;
   endfunction

   always_comb begin
      cell_in     = in_cell;
      cell_in.sat = div_step(in_cell.sat);
      cell_in.hue = div_step(in_cell.hue);
   end

   assign in_ready = !valid_ff || out_ready;

   // Cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         cell_ff <= cell_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cell  = cell_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rhsv_back.sv -----
// Back stage: sign, sector base and wrap of hue, output register
`default_nettype none

module rhsv_back (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  rhsv_pkg::cell_type      in_cell,
   output logic                    out_valid,
   input  wire                     out_ready,
   output rhsv_pkg::pixel_out_type out_pixel
);

   logic                              valid_ff;
   rhsv_pkg::pixel_out_type           pixel_ff;
   rhsv_pkg::pixel_out_type           pixel_in;

   logic signed [rhsv_pkg::HUE_SUM_W-1:0] base;
   logic signed [rhsv_pkg::HUE_SUM_W-1:0] term;
   logic signed [rhsv_pkg::HUE_SUM_W-1:0] sum;

   // Hue assembly
   always_comb begin
      unique case (in_cell.sector)
         rhsv_pkg::SECTOR_GREEN: base = rhsv_pkg::HUE_SUM_W'(rhsv_pkg::HUE_BASE_GRN);
         rhsv_pkg::SECTOR_BLUE:  base = rhsv_pkg::HUE_SUM_W'(rhsv_pkg::HUE_BASE_BLU);
         default:                base = '0;
      endcase
      term = $signed({{(rhsv_pkg::HUE_SUM_W-rhsv_pkg::DIV_STEPS){1'b0}}, in_cell.hue.quo});
      if (in_cell.hue_neg) term = -term;
      sum = base + term;
      if (sum < 0) sum = sum + rhsv_pkg::HUE_SUM_W'(rhsv_pkg::HUE_WRAP);
      if (in_cell.hue_zero) sum = '0;

      pixel_in.hue        = sum[rhsv_pkg::HUE_W-1:0];
      pixel_in.saturation = in_cell.sat_zero ? '0 : in_cell.sat.quo;
      pixel_in.brightness = in_cell.brightness;
   end

   assign in_ready = !valid_ff || out_ready;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rgb_to_hsv_pixel_unit.sv -----
// Path from accepted word to result: front stage, 16 division cells, output register.
// Throughput, unstalled: one word per cycle; each cell resolves one quotient bit per cycle.
// Each stage stalls on its own, so bubbles close up behind a held result.
// Reset: synchronous, active high; clears all stage valid flags, no results pending.
`default_nettype none

`include "assert_macros.svh"

module rgb_to_hsv_pixel_unit (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  rhsv_pkg::pixel_in_type  req_pixel,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output rhsv_pkg::pixel_out_type rsp_pixel
);

   logic               chain_valid [0:rhsv_pkg::DIV_STEPS];
   logic               chain_ready [0:rhsv_pkg::DIV_STEPS];
   rhsv_pkg::cell_type chain_cell  [0:rhsv_pkg::DIV_STEPS];

   rhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pixel  (req_pixel),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_cell  (chain_cell[0])
   );

   // Row of division cells
   for (genvar i = 0; i < rhsv_pkg::DIV_STEPS; i++) begin : g_cell
      rhsv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_cell   (chain_cell[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_cell  (chain_cell[i+1])
      );
   end

   rhsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[rhsv_pkg::DIV_STEPS]),
      .in_ready  (chain_ready[rhsv_pkg::DIV_STEPS]),
      .in_cell   (chain_cell[rhsv_pkg::DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pixel (rsp_pixel)
   );

   // Checks
   `ASSERT_IMPLIES(a_ready_only_on_stall, !req_ready, rsp_valid && !rsp_ready,
                   "input refused while output not stalled")
   `ASSERT_IMPLIES(a_hue_range, rsp_valid, rsp_pixel.hue < rhsv_pkg::HUE_W'(rhsv_pkg::HUE_WRAP),
                   "hue beyond a full turn")
   `ASSERT_IMPLIES(a_grey_hue, rsp_valid && rsp_pixel.saturation == '0, rsp_pixel.hue == '0,
                   "grey pixel with non-zero hue")
   `ASSERT_IMPLIES(a_black_sat, rsp_valid && rsp_pixel.brightness == '0,
                   rsp_pixel.saturation == '0, "black pixel with non-zero saturation")

endmodule

`default_nettype wire

// ----- tb/rgb_to_hsv_pixel_unit_tb.sv -----
// Self-checking testbench for the RGB to HSV pixel unit: directed and random pixels.
module rgb_to_hsv_pixel_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rhsv_pkg::*;

   localparam int IDLE_PCT      = 38;
   localparam int RANDOM_PIXELS = 1530;
   localparam int STALL_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 90;
   localparam int HOLD_AT       = 300;
   localparam int STEADY_FROM   = 700;
   localparam int STEADY_TO     = 1000;
   localparam int DRAIN_AT      = 1200;
   localparam int TAIL_CYCLES   = 30;

   // Expected HSV words, one per accepted pixel, oldest first
   class hsv_board;
      pixel_out_type pending_hsv[$];
      int            accepted;
      int            checked;
      int            mismatches;
      int            grey_seen;
      int            wrap_seen;
      int            sector_seen[3];

      function new();
         accepted   = 0;
         checked    = 0;
         mismatches = 0;
         grey_seen  = 0;
         wrap_seen  = 0;
         foreach (sector_seen[i]) sector_seen[i] = 0;
      endfunction

      // Integer HSV conversion; hue in fixed point with HUE_FRAC_BITS fraction bits
      function pixel_out_type predict_hsv(pixel_in_type px);
         pixel_out_type hsv;
         sector_type    sector;
         int            r, g, b, mx, mn, delta, diff, mag, quo, hue, base;
         r = px.red;
         g = px.green;
         b = px.blue;
         mx = (r > g) ? r : g;
         mx = (mx > b) ? mx : b;
         mn = (r < g) ? r : g;
         mn = (mn < b) ? mn : b;
         delta = mx - mn;
         hue = 0;
         hsv.saturation = (mx != 0) ? SAT_W'((delta * 65535) / mx) : '0;
         hsv.brightness = CH_W'(mx);
         if (delta == 0) begin
            grey_seen++;
         end else begin
            // red beats green on a tie, green beats blue
            if (r == mx) begin
               sector = SECTOR_RED;
               base   = 0;
               diff   = g - b;
            end else if (g == mx) begin
               sector = SECTOR_GREEN;
               base   = 120;
               diff   = b - r;
            end else begin
               sector = SECTOR_BLUE;
               base   = 240;
               diff   = r - g;
            end
            sector_seen[int'(sector)]++;
            mag = (diff < 0) ? -diff : diff;
            quo = ((mag * 60) << HUE_FRAC_BITS) / delta;
            hue = (base << HUE_FRAC_BITS) + ((diff < 0) ? -quo : quo);
            if (hue < 0) begin
               hue += 360 << HUE_FRAC_BITS;
               wrap_seen++;
            end
         end
         hsv.hue = hue[HUE_W-1:0];
         return hsv;
      endfunction

      function void note_pixel(pixel_in_type px);
         accepted++;
         pending_hsv.push_back(predict_hsv(px));
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
      endfunction

      function void check_result(pixel_out_type got);
         pixel_out_type want;
         checked++;
         if (pending_hsv.size() == 0) begin
            flag($sformatf("result h=%0d s=%0d v=%0d with no pixel outstanding",
                           got.hue, got.saturation, got.brightness));
            return;
         end
         want = pending_hsv.pop_front();
         if (got.hue !== want.hue || got.saturation !== want.saturation ||
             got.brightness !== want.brightness)
            flag($sformatf("word %0d: want h=%0d s=%0d v=%0d, got h=%0d s=%0d v=%0d",
                           checked, want.hue, want.saturation, want.brightness,
                           got.hue, got.saturation, got.brightness));
      endfunction

      function bit drained();
         return pending_hsv.size() == 0;
      endfunction
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   pixel_in_type  req_pixel;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   pixel_out_type rsp_pixel;

   hsv_board board;
   bit       steady = 1'b0;
   bit       hold_done = 1'b0;
   int       hold_left = 0;
   int       stall_cycles = 0;

   rgb_to_hsv_pixel_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_pixel (rsp_pixel)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Receiver: random back-pressure, one long hold-off once the pipe has seen traffic
   always @(negedge clock) begin
      if (!hold_done && board.accepted >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_pixel(req_pixel);
         if (rsp_valid && rsp_ready) board.check_result(rsp_pixel);
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("rgb_to_hsv_pixel_unit_tb: errors");
            $finish;
         end
      end
   end

   // Offer one pixel, with random idle cycles in front unless in the steady stretch
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= '{red: r, green: g, blue: b};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (!board.drained()) @(posedge clock);
      @(negedge clock);
   endtask

   // Random pixel biased toward greys, ties, saturated and near-grey colours
   task automatic send_random_pixel();
      logic [7:0] c[3];
      logic [7:0] v;
      int         pick;
      pick = $urandom_range(9);
      foreach (c[i]) c[i] = 8'($urandom_range(255));
      v = 8'($urandom_range(255));
      case (pick)
         5: begin
            c = '{v, v, v};
         end
         6: begin
            c[2'($urandom_range(2))] = v;
            c[2'($urandom_range(2))] = v;
            c[2'($urandom_range(2))] = v;
            foreach (c[i]) if (c[i] > v) c[i] = v;
         end
         7: begin
            foreach (c[i]) c[i] = $urandom_range(1) ? 8'(255 - $urandom_range(2))
                                                   : 8'(($urandom_range(2)));
         end
         8: begin
            c[2'($urandom_range(2))] = 8'd0;
         end
         9: begin
            foreach (c[i]) c[i] = (v > 250) ? 8'(v - $urandom_range(4))
                                            : 8'(v + $urandom_range(4));
         end
         default: begin
         end
      endcase
      send_pixel(c[0], c[1], c[2]);
   endtask

   // Stimulus
   initial begin
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_pixel = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // black, white and greys
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      // primaries and secondaries
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      // negative red-sector hue that wraps just under 360 degrees
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd200, 8'd100, 8'd150);
      // green and blue sectors, both term signs
      send_pixel(8'd10,  8'd200, 8'd5);
      send_pixel(8'd5,   8'd200, 8'd10);
      send_pixel(8'd5,   8'd10,  8'd200);
      send_pixel(8'd10,  8'd5,   8'd200);
      // ties on the maximum
      send_pixel(8'd255, 8'd254, 8'd255);
      send_pixel(8'd100, 8'd200, 8'd200);
      // smallest non-grey steps and a mid orange
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd254, 8'd255, 8'd253);
      send_pixel(8'd255, 8'd128, 8'd0);
      req_valid <= 1'b0;
      wait_drained();

      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         steady = (n >= STEADY_FROM && n < STEADY_TO);
         if (n == DRAIN_AT) begin
            req_valid <= 1'b0;
            wait_drained();
         end
         send_random_pixel();
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("converted %0d pixels: %0d grey or black, sectors r/g/b %0d/%0d/%0d, %0d wrapped",
               board.accepted, board.grey_seen, board.sector_seen[0], board.sector_seen[1],
               board.sector_seen[2], board.wrap_seen);
      $display("checked %0d results under random stalls, one long receiver hold and a drain",
               board.checked);
      if (board.mismatches == 0 && board.drained())
         $display("rgb_to_hsv_pixel_unit_tb: clean");
      else
         $display("rgb_to_hsv_pixel_unit_tb: errors");
      $finish;
   end

endmodule

// ----- rgb_to_hsv_pixel_unit.f -----
+incdir+hw/rtl
hw/rtl/rhsv_pkg.sv
hw/rtl/rhsv_front.sv
hw/rtl/rhsv_div_cell.sv
hw/rtl/rhsv_back.sv
hw/rtl/rgb_to_hsv_pixel_unit.sv
tb/rgb_to_hsv_pixel_unit_tb.sv
